FILE: design/bds_pkg.sv
// Shared constants for the baud divisor search block.
// Used by the bit-serial divider and by the top level; depends on nothing else.
`default_nettype none

package bds_pkg;

    localparam int QUO_W   = 32;   // dividend, divisor and quotient width
    localparam int BAUD_W  = 22;
    localparam int GEN_W   = 16;
    localparam int DIVR_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int CNT_W   = $clog2(QUO_W);

    localparam logic [DIVR_W-1:0] DIVR_FIRST = 8'd4;
    localparam logic [DIVR_W-1:0] DIVR_LAST  = 8'd254;
    localparam logic [GEN_W-1:0]  GEN_MIN    = 16'd2;
    localparam logic [QUO_W-1:0]  GEN_MAX    = 32'd65535;

    localparam logic [QUO_W-1:0]  REF_CLK_RESET = 32'd100000000;

    // Register index, taken from paddr[2].
    localparam logic REG_REF_CLK = 1'b0;

endpackage

`default_nettype wire

FILE: design/bds_div.sv
// Restoring bit-serial divider: one quotient bit per clock, 32 steps.
// Depends on bds_pkg. A zero divisor yields an all-ones quotient.
`default_nettype none

module bds_div
    import bds_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [QUO_W-1:0] num,
    input  wire logic [QUO_W-1:0] den,
    output logic                  done,
    output logic [QUO_W-1:0]      quot
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [QUO_W-1:0] num_reg, num_next;
    logic [QUO_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quot_reg, quot_next;
    logic [QUO_W:0]   trial;
    logic [QUO_W:0]   diff;
    logic             qbit;

    // The partial remainder always stays below the divisor, so one bit of
    // headroom in the trial value is enough.
    assign trial = {rem_reg, num_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[QUO_W-2:0], 1'b0};
            rem_next  = qbit ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
            quot_next = {quot_reg[QUO_W-2:0], qbit};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

FILE: design/baud_divisor_search_unit.sv
// Top level of the baud divisor search: APB register, sequencer and compare.
// Depends on bds_pkg and the bit-serial divider bds_div.
`default_nettype none

// Each word on target_baud is searched over dividers 4 to 254 and yields one
// word with the generator and divider that give the smallest baud error
// (generator 2, divider 4 when nothing beats the target itself). A divider
// value whose generator is in range takes two passes through the single
// bit-serial divider, each a start state followed by a wait state (S_START1
// and S_DIV1, then S_START2 and S_DIV2), and then the compare state S_CMP. A
// candidate whose generator is out of range skips the second pass and the
// compare. After the last divider S_DONE loads the result once the output
// register is free or draining. A finished result waits in that output
// register, so the next word is taken while it is still pending.
// ref_clock_hz sits at byte address 0 and should be written only
// while the block is idle.

module baud_divisor_search_unit
    import bds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BAUD_W-1:0] target_baud,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [GEN_W-1:0]  best_generator,
    output logic      [DIVR_W-1:0] best_divider
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_START1 = 7'b0000010,
        S_DIV1   = 7'b0000100,
        S_START2 = 7'b0001000,
        S_DIV2   = 7'b0010000,
        S_CMP    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [QUO_W-1:0]    ref_clk_reg;
    logic [BAUD_W-1:0]   baud_reg, baud_next;
    logic [DIVR_W-1:0]   d_reg, d_next;
    logic [GEN_W-1:0]    gen_reg, gen_next;
    logic [QUO_W-1:0]    err_reg, err_next;
    logic [BAUD_W-1:0]   best_err_reg, best_err_next;
    logic [GEN_W-1:0]    best_gen_reg, best_gen_next;
    logic [DIVR_W-1:0]   best_d_reg, best_d_next;
    logic                out_valid_reg, out_valid_next;
    logic [GEN_W-1:0]    out_gen_reg, out_gen_next;
    logic [DIVR_W-1:0]   out_d_reg, out_d_next;

    logic [DIVR_W-1:0]   d_plus1;
    logic [29:0]         prod1;
    logic [23:0]         prod2;
    logic                div_start;
    logic [QUO_W-1:0]    div_den;
    logic                div_done;
    logic [QUO_W-1:0]    div_quot;
    logic [QUO_W-1:0]    baud_ext;
    logic                cfg_wr;

    // Configuration register.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REF_CLK) ? ref_clk_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_clk_reg <= REF_CLK_RESET;
        end
        else if (cfg_wr && paddr[2] == REG_REF_CLK)
        begin
            ref_clk_reg <= pwdata;
        end
    end

    // Both products fit without wrapping: 22x8 and 16x8 bits.
    assign d_plus1   = d_reg + 1'b1;
    assign prod1     = 30'(baud_reg) * 30'(d_plus1);
    assign prod2     = 24'(gen_reg) * 24'(d_plus1);
    assign div_start = (state_reg == S_START1) || (state_reg == S_START2);
    assign div_den   = (state_reg == S_START1) ? QUO_W'(prod1) : QUO_W'(prod2);
    assign baud_ext  = QUO_W'(baud_reg);

    bds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ref_clk_reg),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        baud_next      = baud_reg;
        d_next         = d_reg;
        gen_next       = gen_reg;
        err_next       = err_reg;
        best_err_next  = best_err_reg;
        best_gen_next  = best_gen_reg;
        best_d_next    = best_d_reg;
        out_valid_next = out_valid_reg;
        out_gen_next   = out_gen_reg;
        out_d_next     = out_d_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    baud_next     = target_baud;
                    best_err_next = target_baud;
                    best_gen_next = GEN_MIN;
                    best_d_next   = DIVR_FIRST;
                    d_next        = DIVR_FIRST;
                    state_next    = S_START1;
                end
            end
            S_START1:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    gen_next = div_quot[GEN_W-1:0];
                    if (div_quot < QUO_W'(GEN_MIN) || div_quot > GEN_MAX)
                    begin
                        // Generator out of range: move on to the next divider, or finish after the last.
                        if (d_reg == DIVR_LAST)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            d_next     = d_plus1;
                            state_next = S_START1;
                        end
                    end
                    else
                    begin
                        state_next = S_START2;
                    end
                end
            end
            S_START2:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    err_next   = (div_quot > baud_ext) ? (div_quot - baud_ext)
                                                       : (baud_ext - div_quot);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (err_reg < QUO_W'(best_err_reg))
                begin
                    best_err_next = err_reg[BAUD_W-1:0];
                    best_gen_next = gen_reg;
                    best_d_next   = d_reg;
                end
                if (d_reg == DIVR_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    d_next     = d_plus1;
                    state_next = S_START1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_gen_next   = best_gen_reg;
                    out_d_next     = best_d_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        baud_reg     <= baud_next;
        d_reg        <= d_next;
        gen_reg      <= gen_next;
        err_reg      <= err_next;
        best_err_reg <= best_err_next;
        best_gen_reg <= best_gen_next;
        best_d_reg   <= best_d_next;
        out_gen_reg  <= out_gen_next;
        out_d_reg    <= out_d_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign best_generator = out_gen_reg;
    assign best_divider   = out_d_reg;

    // A new word always restarts the sweep at the first divider.
    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_START1 && d_reg == DIVR_FIRST)
        else $error("sweep did not restart at the first divider");

    // The divider index stays within its range during a search.
    a_d_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> d_reg >= DIVR_FIRST && d_reg <= DIVR_LAST)
        else $error("divider index out of range");

    // The divider only finishes while the sequencer waits for it.
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV1 || state_reg == S_DIV2)
        else $error("divider finished outside a wait state");

    // The kept generator never drops below its minimum.
    a_best_gen: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> best_gen_reg >= GEN_MIN)
        else $error("best generator below minimum");

    // A result is only loaded into a free or draining output register.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && !out_ready |=> state_reg == S_DONE)
        else $error("result overwrote a pending word");

endmodule

`default_nettype wire
